@@ rtl/wlsb_pkg.sv @@
// Shared types, codes and helper functions for the W-LSB window encoder.
package wlsb_pkg;

  localparam int VAL_W   = 32;
  localparam int BITS_W  = 6;
  localparam int FILL_W  = 3;
  localparam int FW_W    = 2;

  // Field width codes carried on a query beat.
  localparam logic [FW_W-1:0] FW_8  = 2'd0;
  localparam logic [FW_W-1:0] FW_16 = 2'd1;

  localparam logic [VAL_W-1:0] MASK_8  = 32'h0000_00FF;
  localparam logic [VAL_W-1:0] MASK_16 = 32'h0000_FFFF;
  localparam logic [VAL_W-1:0] MASK_32 = 32'hFFFF_FFFF;

  localparam logic [BITS_W-1:0] BITS_8  = 6'd8;
  localparam logic [BITS_W-1:0] BITS_16 = 6'd16;
  localparam logic [BITS_W-1:0] BITS_32 = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ENCODE
  } wlsb_state_t;

  // Control from the sequencer to the offset accumulator.
  typedef struct packed {
    logic            load;  // start of a query: latch value+shift and mask
    logic            take;  // fold the current RAM read into the accumulator
    logic [FW_W-1:0] fw;    // field width code, sampled on load
  } acc_ctl_t;

  function automatic logic [VAL_W-1:0] width_mask(input logic [FW_W-1:0] fw);
    logic [VAL_W-1:0] m;
    case (fw)
      FW_8:    m = MASK_8;
      FW_16:   m = MASK_16;
      default: m = MASK_32;
    endcase
    return m;
  endfunction

  function automatic logic [BITS_W-1:0] width_bits(input logic [FW_W-1:0] fw);
    logic [BITS_W-1:0] b;
    case (fw)
      FW_8:    b = BITS_8;
      FW_16:   b = BITS_16;
      default: b = BITS_32;
    endcase
    return b;
  endfunction

  // Number of significant bits: position of the highest set bit plus one.
  function automatic logic [BITS_W-1:0] bit_len(input logic [VAL_W-1:0] x);
    logic [BITS_W-1:0] n;
    n = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (x[i]) begin
        n = BITS_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/wlsb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wlsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/wlsb_acc.sv @@
// Shared offset unit: one subtract, mask and OR-accumulate per window entry.
module wlsb_acc
  import wlsb_pkg::*;
(
  input  logic              clk,
  input  acc_ctl_t          ctl,
  input  logic [VAL_W-1:0]  value,
  input  logic [VAL_W-1:0]  shift,
  input  logic [VAL_W-1:0]  entry,
  output logic [BITS_W-1:0] bits
);

  logic [VAL_W-1:0] vp_r,   vp_nxt;
  logic [VAL_W-1:0] mask_r, mask_nxt;
  logic [VAL_W-1:0] or_r,   or_nxt;
  logic [VAL_W-1:0] off;

  // Offset of the query value from the interval base (entry - p).
  assign off = (vp_r - entry) & mask_r;

  always_comb begin
    vp_nxt   = vp_r;
    mask_nxt = mask_r;
    or_nxt   = or_r;
    if (ctl.load) begin
      vp_nxt   = value + shift;
      mask_nxt = width_mask(ctl.fw);
      or_nxt   = '0;
    end else if (ctl.take) begin
      or_nxt   = or_r | off;
    end
  end

  always_ff @(posedge clk) begin
    vp_r   <= vp_nxt;
    mask_r <= mask_nxt;
    or_r   <= or_nxt;
  end

  // The widest offset decides k, and the OR has the same bit length as the max.
  assign bits = bit_len(or_r);

endmodule

@@ rtl/wlsb_window_min_bits_unit.sv @@
// Top level of the W-LSB window encoder: window state, sequencer and ports.
//
// This block keeps a window of up to WINDOW_DEPTH reference values for
// window-based LSB header compression. A beat with in_tuser low adds
// in_tdata's value at the write pointer; it produces no result and the block
// is ready again on the next cycle. A beat with in_tuser high is a query: the
// block returns on the out channel the least number of LSBs k up to the field
// width W (8, 16 or 32; code 3 acts as 32) such that the value modulo 2^W lies
// in [ref - p, ref - p + 2^k - 1] for every used entry, or W if no k fits or the
// fill count is zero. A query walks the window through one RAM read port and
// one shared subtract/OR unit, one entry per cycle, so it holds in_tready low
// through the scan, drain and encode states until the result is loaded, and
// longer while the previous result waits on out_tready. The result register
// lets a new beat be accepted while the last result is still waiting. cfg_wr_en
// writes the fill limit (reset 4), the most entries the fill count reaches;
// write it only while the block is idle.
module wlsb_window_min_bits_unit
  import wlsb_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // value [31:0], shift [63:32], field_width [65:64], zero pad
  input  logic        in_tuser,   // action: 0 add, 1 query
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bits_needed [5:0], zero pad
  // Configuration port.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data // fill limit
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_DEPTH - 1);

  // Input beat fields.
  logic [VAL_W-1:0] in_value;
  logic [VAL_W-1:0] in_shift;
  logic [FW_W-1:0]  in_fw;
  assign in_value = in_tdata[31:0];
  assign in_shift = in_tdata[63:32];
  assign in_fw    = in_tdata[65:64];

  wlsb_state_t state_r, state_nxt;

  logic [FILL_W-1:0]       win_width_r;
  logic [FILL_W-1:0]       fill_r,    fill_nxt;
  logic [PTR_W-1:0]        wptr_r,    wptr_nxt;
  logic [WINDOW_DEPTH-1:0] used_r,    used_nxt;
  logic [PTR_W-1:0]        idx_r,     idx_nxt;
  logic                    rd_vld_r,  rd_vld_nxt;
  logic                    rd_used_r, rd_used_nxt;
  logic [FW_W-1:0]         fw_r,      fw_nxt;
  logic                    empty_r,   empty_nxt;
  logic                    ovalid_r,  ovalid_nxt;
  logic [BITS_W-1:0]       obits_r,   obits_nxt;

  logic             accept;
  logic             add_beat;
  logic [VAL_W-1:0] rd_data;
  logic [BITS_W-1:0] acc_bits;
  acc_ctl_t         acc_ctl;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign add_beat  = accept && !in_tuser;

  wlsb_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (add_beat),
    .wr_addr (wptr_r),
    .wr_data (in_value),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  wlsb_acc u_acc (
    .clk   (clk),
    .ctl   (acc_ctl),
    .value (in_value),
    .shift (in_shift),
    .entry (rd_data),
    .bits  (acc_bits)
  );

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    wptr_nxt    = wptr_r;
    used_nxt    = used_r;
    idx_nxt     = idx_r;
    rd_vld_nxt  = 1'b0;
    rd_used_nxt = 1'b0;
    fw_nxt      = fw_r;
    empty_nxt   = empty_r;
    ovalid_nxt  = ovalid_r;
    obits_nxt   = obits_r;

    acc_ctl.load = 1'b0;
    acc_ctl.take = rd_vld_r && rd_used_r;
    acc_ctl.fw   = in_fw;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser) begin
            acc_ctl.load = 1'b1;
            fw_nxt       = in_fw;
            empty_nxt    = (fill_r == '0);
            idx_nxt      = '0;
            state_nxt    = ST_SCAN;
          end else begin
            // The count saturates at the configured width; storage always wraps.
            if (fill_r < win_width_r) begin
              fill_nxt = fill_r + FILL_W'(1);
            end
            used_nxt[wptr_r] = 1'b1;
            wptr_nxt = (wptr_r == LAST_IDX) ? '0 : wptr_r + PTR_W'(1);
          end
        end
      end
      ST_SCAN: begin
        // Address idx_r is on the RAM now; its data is folded in next cycle.
        rd_vld_nxt  = 1'b1;
        rd_used_nxt = used_r[idx_r];
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + PTR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_ENCODE;
      end
      ST_ENCODE: begin
        if (!ovalid_r || out_tready) begin
          obits_nxt  = empty_r ? width_bits(fw_r) : acc_bits;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_width_r <= FILL_W'(4);
      fill_r      <= '0;
      wptr_r      <= '0;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        win_width_r <= cfg_wr_data;
      end
      fill_r   <= fill_nxt;
      wptr_r   <= wptr_nxt;
      used_r   <= used_nxt;
      rd_vld_r <= rd_vld_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    rd_used_r <= rd_used_nxt;
    fw_r      <= fw_nxt;
    empty_r   <= empty_nxt;
    obits_r   <= obits_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, obits_r};

endmodule

@@ rtl/wlsb_checker.sv @@
// Port-level checker for the W-LSB window encoder, bound to its top level.
module wlsb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // A result never exceeds the widest field and the pad bits stay zero.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:6] == 2'b00) && (out_tdata[5:0] <= 6'd32))
    else $error("result out of range");

  // A query beat occupies the block: it is not ready on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("ready right after a query beat");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind wlsb_window_min_bits_unit wlsb_checker u_wlsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
